// File: hw/rtl/rmdq_pkg.sv
`timescale 1ns / 1ps

package rmdq_pkg;

   localparam int ROT_W      = 16;
   localparam int TRANS_W    = 24;
   localparam int REQ_DATA_W = 9 * ROT_W + 3 * TRANS_W;
   localparam int RSP_DATA_W = 4 * ROT_W + 4 * TRANS_W;

   localparam int Q_W        = ROT_W + 2;
   localparam int P_W        = Q_W + TRANS_W + 2;
   localparam int N_W        = 2 * Q_W;
   localparam int H_W        = 5;
   localparam int M_W        = 62;
   localparam int ROOT_W     = M_W / 2;
   localparam int QUO_W      = ROOT_W + 2;

   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam int SH_REAL = 48;
   localparam int SH_DUAL = 63;

   localparam logic signed [Q_W-1:0] ONE_Q14 = Q_W'(16384);

   typedef struct packed {
      logic [3:0][Q_W-1:0] q;
      logic [3:0][P_W-1:0] p;
      logic [H_W-1:0]      h;
      logic                deg;
   } side_type;

endpackage

// File: hw/rtl/rmdq_pipe_ctrl.sv
`timescale 1ns / 1ps

module rmdq_pipe_ctrl #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             out_ready,
   output logic             in_ready,
   output logic [DEPTH-1:0] en,
   output logic [DEPTH-1:0] valid
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   always_comb begin
      en[DEPTH-1] = !valid_ff[DEPTH-1] || out_ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < DEPTH; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = en[0];
   assign valid    = valid_ff;

endmodule

// File: hw/rtl/rmdq_delay.sv
`timescale 1ns / 1ps

module rmdq_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_tap
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en[g]) begin
               data_ff[g] <= din;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en[g]) begin
               data_ff[g] <= data_ff[g-1];
            end
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

// File: hw/rtl/rmdq_isqrt.sv
`timescale 1ns / 1ps

module rmdq_isqrt
   import rmdq_pkg::*;
(
   input  logic                   clock,
   input  logic [SQRT_STAGES-1:0] en,
   input  logic [M_W-1:0]         radicand,
   output logic [ROOT_W-1:0]      root
);

   localparam int REM_W = ROOT_W + 4;

   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [M_W-1:0]    rad_ff  [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [M_W-1:0]    rad_prev;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [M_W-1:0]    rad_in;
      logic [REM_W-1:0]  trial;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
      end

      always_comb begin
         rem_in  = rem_prev;
         root_in = root_prev;
         rad_in  = rad_prev;
         trial   = '0;
         for (int j = 0; j < SQRT_STEPS; j++) begin
            if (g * SQRT_STEPS + j < ROOT_W) begin
               rem_in = {rem_in[REM_W-3:0], rad_in[M_W-1 -: 2]};
               rad_in = {rad_in[M_W-3:0], 2'b00};
               trial  = {2'b00, root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            rad_ff[g]  <= rad_in;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

// File: hw/rtl/rmdq_recip.sv
`timescale 1ns / 1ps

module rmdq_recip
   import rmdq_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  logic [ROOT_W-1:0]     divisor,
   output logic [QUO_W-1:0]      quotient
);

   localparam int DREM_W = ROOT_W + 1;

   logic [DREM_W-1:0] rem_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff [DIV_STAGES];
   logic [ROOT_W-1:0] div_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [DREM_W-1:0] rem_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [ROOT_W-1:0] div_prev;
      logic [DREM_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (g == 0) begin : g_first
         assign rem_prev = DREM_W'(1) << (ROOT_W - 2);
         assign quo_prev = '0;
         assign div_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign quo_prev = quo_ff[g-1];
         assign div_prev = div_ff[g-1];
      end

      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (g * DIV_STEPS + j < QUO_W) begin
               rem_in = {rem_in[DREM_W-2:0], 1'b0};
               if (rem_in >= {1'b0, div_prev}) begin
                  rem_in = rem_in - {1'b0, div_prev};
                  quo_in = {quo_in[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[QUO_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            div_ff[g] <= div_prev;
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

// File: hw/rtl/rigid_matrix_to_dual_quaternion_unit.sv
// Converts one rigid transform per item (a Q2.14 rotation matrix and a Q12.12
// translation) into a unit dual quaternion, and accepts a new item in every
// cycle while the result side keeps up; on its way each item passes the
// 16-stage square-root pipeline and the 17-stage reciprocal pipeline that
// normalize the rotation quaternion, and a stall on the result side holds
// only as many stages as are full.
`timescale 1ns / 1ps

module rigid_matrix_to_dual_quaternion_unit
   import rmdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
   // trans_x, trans_y, trans_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // real_x, real_y, real_z, real_w, dual_x, dual_y, dual_z, dual_w
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic                  rsp_tuser
);

   localparam int ST_IN    = 0;
   localparam int ST_MUL   = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_NORM  = 3;
   localparam int ST_SHIFT = 4;
   localparam int ST_SQRT  = 5;
   localparam int ST_DIV   = ST_SQRT + SQRT_STAGES;
   localparam int ST_PROD  = ST_DIV + DIV_STAGES;
   localparam int ST_ADD   = ST_PROD + 1;
   localparam int ST_RND   = ST_PROD + 2;
   localparam int ST_OUT   = ST_PROD + 3;
   localparam int DEPTH    = ST_OUT + 1;

   localparam int TERM_W  = Q_W + TRANS_W;
   localparam int MQ_W    = Q_W - 1;
   localparam int RP_W    = MQ_W + QUO_W;
   localparam int RS_W    = RP_W + 1;
   localparam int RM_W    = RS_W - (SH_REAL - 30);
   localparam int PL_W    = P_W / 2;
   localparam int PH_W    = P_W - PL_W;
   localparam int DP_W    = PH_W + QUO_W;
   localparam int DS_W    = P_W + QUO_W;
   localparam int DM_W    = DS_W - (SH_DUAL - 30);
   localparam int SA_W    = $clog2(SH_DUAL + 1);

   localparam logic [RM_W-1:0] REAL_POS = RM_W'((1 << (ROT_W - 1)) - 1);
   localparam logic [DM_W-1:0] DUAL_POS = DM_W'((1 << (TRANS_W - 1)) - 1);

   logic [DEPTH-1:0] en;
   logic [DEPTH-1:0] valid;

   rmdq_pipe_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_ready(rsp_tready),
      .in_ready (req_tready),
      .en       (en),
      .valid    (valid)
   );

   logic signed [ROT_W-1:0]   rot [9];
   logic signed [TRANS_W-1:0] trans [3];
   logic signed [Q_W-1:0]     re [9];
   logic signed [Q_W-1:0]     q_in [4];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rot[k] = req_tdata[k*ROT_W +: ROT_W];
         re[k]  = Q_W'(rot[k]);
      end
      for (int k = 0; k < 3; k++) begin
         trans[k] = req_tdata[9*ROT_W + k*TRANS_W +: TRANS_W];
      end
      if (re[8] < 0) begin
         if (re[0] > re[4]) begin
            q_in[0] = ONE_Q14 + re[0] - re[4] - re[8];
            q_in[1] = re[1] + re[3];
            q_in[2] = re[6] + re[2];
            q_in[3] = re[5] - re[7];
         end else begin
            q_in[0] = re[1] + re[3];
            q_in[1] = ONE_Q14 - re[0] + re[4] - re[8];
            q_in[2] = re[5] + re[7];
            q_in[3] = re[6] - re[2];
         end
      end else begin
         if (re[0] < -re[4]) begin
            q_in[0] = re[6] + re[2];
            q_in[1] = re[5] + re[7];
            q_in[2] = ONE_Q14 - re[0] - re[4] + re[8];
            q_in[3] = re[1] - re[3];
         end else begin
            q_in[0] = re[5] - re[7];
            q_in[1] = re[6] - re[2];
            q_in[2] = re[1] - re[3];
            q_in[3] = ONE_Q14 + re[0] + re[4] + re[8];
         end
      end
   end

   logic signed [Q_W-1:0]     q_s0_ff [4];
   logic signed [TRANS_W-1:0] t_s0_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         for (int i = 0; i < 4; i++) q_s0_ff[i] <= q_in[i];
         for (int i = 0; i < 3; i++) t_s0_ff[i] <= trans[i];
      end
   end

   function automatic logic signed [TERM_W-1:0] mul_term(
      input logic signed [TRANS_W-1:0] t,
      input logic signed [Q_W-1:0]     q
   );
      return TERM_W'(t) * TERM_W'(q);
   endfunction

   logic signed [TERM_W-1:0] tm_in [12];
   logic signed [TERM_W-1:0] tm_s1_ff [12];
   logic [N_W-1:0]           sq_s1_ff [4];
   logic signed [Q_W-1:0]    q_s1_ff [4];

   always_comb begin
      tm_in[0]  = mul_term(t_s0_ff[0], q_s0_ff[3]);
      tm_in[1]  = mul_term(t_s0_ff[1], q_s0_ff[2]);
      tm_in[2]  = mul_term(t_s0_ff[2], q_s0_ff[1]);
      tm_in[3]  = mul_term(t_s0_ff[1], q_s0_ff[3]);
      tm_in[4]  = mul_term(t_s0_ff[2], q_s0_ff[0]);
      tm_in[5]  = mul_term(t_s0_ff[0], q_s0_ff[2]);
      tm_in[6]  = mul_term(t_s0_ff[2], q_s0_ff[3]);
      tm_in[7]  = mul_term(t_s0_ff[0], q_s0_ff[1]);
      tm_in[8]  = mul_term(t_s0_ff[1], q_s0_ff[0]);
      tm_in[9]  = mul_term(t_s0_ff[0], q_s0_ff[0]);
      tm_in[10] = mul_term(t_s0_ff[1], q_s0_ff[1]);
      tm_in[11] = mul_term(t_s0_ff[2], q_s0_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         for (int i = 0; i < 12; i++) tm_s1_ff[i] <= tm_in[i];
         for (int i = 0; i < 4; i++) begin
            sq_s1_ff[i] <= N_W'(N_W'(q_s0_ff[i]) * N_W'(q_s0_ff[i]));
            q_s1_ff[i]  <= q_s0_ff[i];
         end
      end
   end

   logic signed [P_W-1:0] p_in [4];
   logic signed [P_W-1:0] p_s2_ff [4];
   logic [N_W-1:0]        n_s2_ff;
   logic signed [Q_W-1:0] q_s2_ff [4];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = P_W'(tm_s1_ff[3*i]) + P_W'(tm_s1_ff[3*i+1]) - P_W'(tm_s1_ff[3*i+2]);
      end
      p_in[3] = P_W'(0) - P_W'(tm_s1_ff[9]) - P_W'(tm_s1_ff[10]) - P_W'(tm_s1_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         for (int i = 0; i < 4; i++) begin
            p_s2_ff[i] <= p_in[i];
            q_s2_ff[i] <= q_s1_ff[i];
         end
         n_s2_ff <= sq_s1_ff[0] + sq_s1_ff[1] + sq_s1_ff[2] + sq_s1_ff[3];
      end
   end

   logic [$clog2(N_W)-1:0] lead;
   logic [SA_W-1:0]        h_span;
   side_type               side_s3_ff;
   logic [N_W-1:0]         n_s3_ff;

   always_comb begin
      lead = '0;
      for (int b = 0; b < N_W; b++) begin
         if (n_s2_ff[b]) lead = b[$clog2(N_W)-1:0];
      end
      h_span = SA_W'(M_W - 1) - SA_W'(lead);
   end

   always_ff @(posedge clock) begin
      if (en[ST_NORM]) begin
         for (int i = 0; i < 4; i++) begin
            side_s3_ff.q[i] <= q_s2_ff[i];
            side_s3_ff.p[i] <= p_s2_ff[i];
         end
         side_s3_ff.h   <= h_span[H_W:1];
         side_s3_ff.deg <= (n_s2_ff == '0);
         n_s3_ff        <= n_s2_ff;
      end
   end

   side_type       side_s4_ff;
   logic [M_W-1:0] m_s4_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SHIFT]) begin
         side_s4_ff <= side_s3_ff;
         m_s4_ff    <= M_W'(n_s3_ff) << {side_s3_ff.h, 1'b0};
      end
   end

   logic [ROOT_W-1:0] root;
   logic [QUO_W-1:0]  quo;
   side_type          side_dly;

   rmdq_isqrt u_isqrt (
      .clock   (clock),
      .en      (en[ST_DIV-1:ST_SQRT]),
      .radicand(m_s4_ff),
      .root    (root)
   );

   rmdq_recip u_recip (
      .clock   (clock),
      .en      (en[ST_PROD-1:ST_DIV]),
      .divisor (root),
      .quotient(quo)
   );

   rmdq_delay #(
      .WIDTH($bits(side_type)),
      .DEPTH(SQRT_STAGES + DIV_STAGES)
   ) u_side_delay (
      .clock(clock),
      .en   (en[ST_PROD-1:ST_SQRT]),
      .din  (side_s4_ff),
      .dout (side_dly)
   );

   logic [RP_W-1:0] rp_sa_ff [4];
   logic [DP_W-1:0] dlo_sa_ff [4];
   logic [DP_W-1:0] dhi_sa_ff [4];
   logic [3:0]      qneg_sa_ff;
   logic [3:0]      pneg_sa_ff;
   logic [H_W-1:0]  h_sa_ff;
   logic            deg_sa_ff;
   logic [Q_W-1:0]  qabs [4];
   logic [P_W-1:0]  pabs [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qabs[i] = side_dly.q[i][Q_W-1] ? Q_W'(-$signed(side_dly.q[i])) : side_dly.q[i];
         pabs[i] = side_dly.p[i][P_W-1] ? P_W'(-$signed(side_dly.p[i])) : side_dly.p[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         for (int i = 0; i < 4; i++) begin
            rp_sa_ff[i]  <= RP_W'(qabs[i][MQ_W-1:0]) * RP_W'(quo);
            dlo_sa_ff[i] <= DP_W'(pabs[i][PL_W-1:0]) * DP_W'(quo);
            dhi_sa_ff[i] <= DP_W'(pabs[i][P_W-1:PL_W]) * DP_W'(quo);
            qneg_sa_ff[i] <= side_dly.q[i][Q_W-1];
            pneg_sa_ff[i] <= side_dly.p[i][P_W-1];
         end
         h_sa_ff   <= side_dly.h;
         deg_sa_ff <= side_dly.deg;
      end
   end

   logic [RS_W-1:0] rs_sb_ff [4];
   logic [DS_W-1:0] ds_sb_ff [4];
   logic [3:0]      qneg_sb_ff;
   logic [3:0]      pneg_sb_ff;
   logic [H_W-1:0]  h_sb_ff;
   logic            deg_sb_ff;

   always_ff @(posedge clock) begin
      if (en[ST_ADD]) begin
         for (int i = 0; i < 4; i++) begin
            rs_sb_ff[i] <= RS_W'(rp_sa_ff[i])
                         + (RS_W'(1) << (SA_W'(SH_REAL - 1) - SA_W'(h_sa_ff)));
            ds_sb_ff[i] <= (DS_W'(dhi_sa_ff[i]) << PL_W) + DS_W'(dlo_sa_ff[i])
                         + (DS_W'(1) << (SA_W'(SH_DUAL - 1) - SA_W'(h_sa_ff)));
         end
         qneg_sb_ff <= qneg_sa_ff;
         pneg_sb_ff <= pneg_sa_ff;
         h_sb_ff    <= h_sa_ff;
         deg_sb_ff  <= deg_sa_ff;
      end
   end

   logic [RM_W-1:0] rm_sc_ff [4];
   logic [DM_W-1:0] dm_sc_ff [4];
   logic [3:0]      qneg_sc_ff;
   logic [3:0]      pneg_sc_ff;
   logic            deg_sc_ff;
   logic [RS_W-1:0] rs_shift [4];
   logic [DS_W-1:0] ds_shift [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rs_shift[i] = rs_sb_ff[i] >> (SA_W'(SH_REAL) - SA_W'(h_sb_ff));
         ds_shift[i] = ds_sb_ff[i] >> (SA_W'(SH_DUAL) - SA_W'(h_sb_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_RND]) begin
         for (int i = 0; i < 4; i++) begin
            rm_sc_ff[i] <= rs_shift[i][RM_W-1:0];
            dm_sc_ff[i] <= ds_shift[i][DM_W-1:0];
         end
         qneg_sc_ff <= qneg_sb_ff;
         pneg_sc_ff <= pneg_sb_ff;
         deg_sc_ff  <= deg_sb_ff;
      end
   end

   function automatic logic [ROT_W-1:0] sat_real(
      input logic            neg,
      input logic [RM_W-1:0] mag
   );
      if (!neg) begin
         return (mag > REAL_POS) ? REAL_POS[ROT_W-1:0] : mag[ROT_W-1:0];
      end
      return (mag > REAL_POS + RM_W'(1)) ? {1'b1, {(ROT_W - 1){1'b0}}}
                                         : ROT_W'(~mag[ROT_W-1:0] + ROT_W'(1));
   endfunction

   function automatic logic [TRANS_W-1:0] sat_dual(
      input logic            neg,
      input logic [DM_W-1:0] mag
   );
      if (!neg) begin
         return (mag > DUAL_POS) ? DUAL_POS[TRANS_W-1:0] : mag[TRANS_W-1:0];
      end
      return (mag > DUAL_POS + DM_W'(1)) ? {1'b1, {(TRANS_W - 1){1'b0}}}
                                         : TRANS_W'(~mag[TRANS_W-1:0] + TRANS_W'(1));
   endfunction

   logic [ROT_W-1:0]   real_ff [4];
   logic [TRANS_W-1:0] dual_ff [4];
   logic               deg_ff;

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         for (int i = 0; i < 4; i++) begin
            real_ff[i] <= sat_real(qneg_sc_ff[i], rm_sc_ff[i]);
            dual_ff[i] <= sat_dual(pneg_sc_ff[i], dm_sc_ff[i]);
         end
         deg_ff <= deg_sc_ff;
      end
   end

   assign rsp_tvalid = valid[ST_OUT];
   assign rsp_tdata  = {dual_ff[3], dual_ff[2], dual_ff[1], dual_ff[0],
                        real_ff[3], real_ff[2], real_ff[1], real_ff[0]};
   assign rsp_tuser  = deg_ff;

`ifndef SYNTH
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate item carries nonzero quaternion");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the result side is free");

   a_recip_range: assert property (@(posedge clock) disable iff (reset)
      valid[ST_PROD-1] && !side_dly.deg |-> quo[QUO_W-1] || quo[QUO_W-2])
      else $error("reciprocal root out of its normalized range");
`endif

endmodule
